FILE: rtl/core/fbc_pkg.sv
// Shared types and constants for the footswitch bypass controller.
package fbc_pkg;

  localparam int unsigned CfgAddrWidth = 4;
  localparam int unsigned CfgDataWidth = 32;

  localparam logic [15:0] DebounceMsReset    = 16'd100;
  localparam logic [15:0] HoldMsReset        = 16'd5000;
  localparam logic [15:0] BlinkWindowMsReset = 16'd100;

  localparam logic [15:0] CountMax = 16'hFFFF;

  localparam logic [7:0] BlinkPeriodLast = 8'd249;
  localparam logic [7:0] BlinkOnMax      = 8'd125;

  typedef enum logic [1:0] {
    RegDebounceMs    = 2'd0,
    RegHoldMs        = 2'd1,
    RegBlinkWindowMs = 2'd2,
    RegStartupMode   = 2'd3
  } reg_idx_e;

  typedef enum logic {
    ModeToggle    = 1'b0,
    ModeMomentary = 1'b1
  } mode_e;

  localparam mode_e StartupModeReset = ModeToggle;

  typedef struct packed {
    logic stable;
    logic press;
  } btn_t;

  typedef struct packed {
    logic fet_wet;
    logic fet_dry;
    logic led_toggle_lit;
    logic led_momentary_lit;
    logic current_mode;
    logic save_mode;
  } res_t;

endpackage

FILE: rtl/core/fbc_debounce.sv
// Switch debouncer and press detector.
module fbc_debounce (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          advance_i,
  input  logic          raw_button_i,
  input  logic [15:0]   debounce_ms_i,
  output fbc_pkg::btn_t btn_o
);
  import fbc_pkg::*;

  logic        last_raw_q, last_raw_d;
  logic [15:0] count_q, count_d;
  logic        stable_q, stable_d;
  logic        prev_stable_q;

  always_comb begin
    last_raw_d = last_raw_q;
    count_d    = count_q;
    stable_d   = stable_q;
    if (raw_button_i != last_raw_q) begin
      last_raw_d = raw_button_i;
      count_d    = '0;
    end else begin
      count_d = (count_q == CountMax) ? count_q : count_q + 16'd1;
      if (count_d >= debounce_ms_i) begin
        stable_d = raw_button_i;
      end
    end
  end

  // Active-low switch: a press is the falling edge of the debounced level.
  assign btn_o.stable = stable_d;
  assign btn_o.press  = !stable_d && prev_stable_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_raw_q    <= 1'b1;
      count_q       <= '0;
      stable_q      <= 1'b1;
      prev_stable_q <= 1'b1;
    end else if (advance_i) begin
      last_raw_q    <= last_raw_d;
      count_q       <= count_d;
      stable_q      <= stable_d;
      prev_stable_q <= stable_d;
    end
  end

endmodule

FILE: rtl/core/fbc_hold.sv
// Effect state, hold timer, mode switching and LED blink logic.
module fbc_hold (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          advance_i,
  input  fbc_pkg::btn_t btn_i,
  input  logic [15:0]   hold_ms_i,
  input  logic [15:0]   blink_window_ms_i,
  input  logic          mode_load_i,
  input  logic          mode_value_i,
  output fbc_pkg::res_t res_o
);
  import fbc_pkg::*;

  logic        effect_q, effect_d;
  logic        mode_q, mode_d;
  logic        done_q, done_d;
  logic [15:0] elapsed_q, elapsed_d;
  logic [7:0]  phase_q, phase_d;
  logic        imminent;
  logic        flip;
  logic        blink;
  logic [15:0] threshold;

  assign threshold = (blink_window_ms_i > hold_ms_i) ? '0 : hold_ms_i - blink_window_ms_i;

  always_comb begin
    effect_d = effect_q;
    if (mode_q == ModeToggle) begin
      if (btn_i.press) begin
        effect_d = !effect_q;
      end
    end else begin
      effect_d = !btn_i.stable;
    end
  end

  // The phase counter tracks the elapsed count modulo the blink period.
  // The warning flag is rebuilt on every tick, so it needs no register.
  always_comb begin
    elapsed_d = '0;
    phase_d   = '0;
    done_d    = 1'b0;
    imminent  = 1'b0;
    flip      = 1'b0;
    if (!btn_i.stable) begin
      if (elapsed_q == CountMax) begin
        elapsed_d = elapsed_q;
        phase_d   = phase_q;
      end else begin
        elapsed_d = elapsed_q + 16'd1;
        phase_d   = (phase_q == BlinkPeriodLast) ? '0 : phase_q + 8'd1;
      end
      flip     = (elapsed_d >= hold_ms_i) && !done_q;
      done_d   = done_q || flip;
      imminent = (elapsed_d < hold_ms_i) && (elapsed_d >= threshold);
    end
  end

  assign mode_d = mode_q ^ flip;
  assign blink  = imminent && (phase_d <= BlinkOnMax);

  assign res_o.fet_wet           = effect_d;
  assign res_o.fet_dry           = !effect_d;
  assign res_o.led_toggle_lit    = ((mode_d == ModeToggle) && effect_d && !blink) ||
                                   ((mode_d == ModeMomentary) && blink);
  assign res_o.led_momentary_lit = ((mode_d == ModeMomentary) && effect_d && !blink) ||
                                   ((mode_d == ModeToggle) && blink);
  assign res_o.current_mode      = mode_d;
  assign res_o.save_mode         = flip;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      effect_q  <= 1'b0;
      mode_q    <= StartupModeReset;
      done_q    <= 1'b0;
      elapsed_q <= '0;
      phase_q   <= '0;
    end else if (advance_i) begin
      effect_q  <= effect_d;
      mode_q    <= mode_d;
      done_q    <= done_d;
      elapsed_q <= elapsed_d;
      phase_q   <= phase_d;
    end else if (mode_load_i) begin
      mode_q <= mode_value_i;
    end
  end

endmodule

FILE: rtl/core/fbc_outbuf.sv
// Two-entry output buffer: result register plus skid stage.
module fbc_outbuf (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  fbc_pkg::res_t data_i,
  output logic          full_o,
  output logic          valid_o,
  input  logic          stall_i,
  output fbc_pkg::res_t data_o
);
  import fbc_pkg::*;

  logic valid_q;
  logic skid_valid_q;
  res_t data_q;
  res_t skid_q;
  logic pop;

  assign pop     = valid_q && !stall_i;
  assign full_o  = skid_valid_q;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (pop) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else begin
        valid_q <= push_i;
      end
    end else if (push_i) begin
      if (!valid_q) begin
        valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (skid_valid_q) begin
        data_q <= skid_q;
      end else if (push_i) begin
        data_q <= data_i;
      end
    end else if (push_i) begin
      if (!valid_q) begin
        data_q <= data_i;
      end else begin
        skid_q <= data_i;
      end
    end
  end

endmodule

FILE: rtl/core/footswitch_bypass_controller_core.sv
// An accepted word's result is registered in the output buffer and shown after earlier results.
// Throughput: one word per cycle unless stalled; all per-tick state updates in the accepting cycle.
// A two-entry output buffer keeps input flowing while one result waits to be taken.
// Reset (rst_ni low, asynchronous) releases the switch state, clears the effect and
// counters, empties the buffer, and loads the configuration reset values.
module footswitch_bypass_controller_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             raw_button_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             fet_wet_o,
  output logic                             fet_dry_o,
  output logic                             led_toggle_lit_o,
  output logic                             led_momentary_lit_o,
  output logic                             current_mode_o,
  output logic                             save_mode_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [fbc_pkg::CfgAddrWidth-1:0] paddr,
  input  logic [fbc_pkg::CfgDataWidth-1:0] pwdata,
  output logic [fbc_pkg::CfgDataWidth-1:0] prdata,
  output logic                             pready
);
  import fbc_pkg::*;

  logic [15:0] debounce_ms_q;
  logic [15:0] hold_ms_q;
  logic [15:0] blink_window_ms_q;
  logic        startup_mode_q;
  logic        cfg_wr;
  reg_idx_e    cfg_idx;
  logic        advance;
  logic        buf_full;
  btn_t        btn;
  res_t        res;
  res_t        out_res;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_ms_q     <= DebounceMsReset;
      hold_ms_q         <= HoldMsReset;
      blink_window_ms_q <= BlinkWindowMsReset;
      startup_mode_q    <= StartupModeReset;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        RegDebounceMs:    debounce_ms_q     <= pwdata[15:0];
        RegHoldMs:        hold_ms_q         <= pwdata[15:0];
        RegBlinkWindowMs: blink_window_ms_q <= pwdata[15:0];
        RegStartupMode:   startup_mode_q    <= pwdata[0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      RegDebounceMs:    prdata = {16'd0, debounce_ms_q};
      RegHoldMs:        prdata = {16'd0, hold_ms_q};
      RegBlinkWindowMs: prdata = {16'd0, blink_window_ms_q};
      RegStartupMode:   prdata = {31'd0, startup_mode_q};
      default:          prdata = '0;
    endcase
  end

  assign in_stall_o = buf_full;
  assign advance    = in_valid_i && !in_stall_o;

  fbc_debounce u_debounce (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .advance_i     (advance),
    .raw_button_i  (raw_button_i),
    .debounce_ms_i (debounce_ms_q),
    .btn_o         (btn)
  );

  // Writing the startup mode also reloads the live mode, unless a word is accepted in the same cycle.
  fbc_hold u_hold (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .advance_i         (advance),
    .btn_i             (btn),
    .hold_ms_i         (hold_ms_q),
    .blink_window_ms_i (blink_window_ms_q),
    .mode_load_i       (cfg_wr && (cfg_idx == RegStartupMode)),
    .mode_value_i      (pwdata[0]),
    .res_o             (res)
  );

  fbc_outbuf u_outbuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (advance),
    .data_i  (res),
    .full_o  (buf_full),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (out_res)
  );

  assign fet_wet_o           = out_res.fet_wet;
  assign fet_dry_o           = out_res.fet_dry;
  assign led_toggle_lit_o    = out_res.led_toggle_lit;
  assign led_momentary_lit_o = out_res.led_momentary_lit;
  assign current_mode_o      = out_res.current_mode;
  assign save_mode_o         = out_res.save_mode;

`ifndef ASSERT_OFF
  a_fet_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (fet_wet_o != fet_dry_o))
    else $error("wet and dry FET enables not complementary");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled while output buffer holds no word");

  a_no_word_lost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && out_valid_o && out_stall_i) |=> (out_valid_o && in_stall_o))
    else $error("word accepted behind a stalled result was not held");

  a_save_flips_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && res.save_mode) |=> $past(res.current_mode) != $past(u_hold.mode_q))
    else $error("save flag raised without a mode change");
`endif

endmodule
